// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define TCQ_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// antecedent in one cycle implies the consequent in the next
`define TCQ_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/tcq_pkg.sv =====
// types and constants of the two-class oldest-first queue
`default_nettype none

package tcq_pkg;

    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int TAG_W    = 16;
    localparam int STAMP_W  = 8;
    localparam int NUM_CLS  = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENQ       = 2'd0,
        KIND_DEQ_ANY   = 2'd1,
        KIND_DEQ_CLASS = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_LOOKUP,
        CS_EXEC
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/tcq_if.sv =====
// request and response channel interfaces
`default_nettype none

interface tcq_req_if;
    import tcq_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic                item_class;
    logic [TAG_W-1:0]    item_tag;

    modport source (output valid, output kind, output item_class, output item_tag,
                    input ready);
    modport sink   (input valid, input kind, input item_class, input item_tag,
                    output ready);
endinterface

interface tcq_rsp_if;
    import tcq_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                out_class;
    logic [TAG_W-1:0]    out_tag;

    modport source (output valid, output status, output out_class, output out_tag,
                    input ready);
    modport sink   (input valid, input status, input out_class, input out_tag,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tcq_datapath.sv =====
// queue storage, pointers, arrival counter, age compare and result register
`default_nettype none

module tcq_datapath #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire tcq_pkg::ctrl_cmd_t           cmd,
    input  wire logic [tcq_pkg::KIND_W-1:0]   kind,
    input  wire logic                         item_class,
    input  wire logic [tcq_pkg::TAG_W-1:0]    item_tag,
    output logic [tcq_pkg::STATUS_W-1:0]      status,
    output logic                              out_class,
    output logic [tcq_pkg::TAG_W-1:0]         out_tag
);
    import tcq_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W = TAG_BITS + STAMP_W;

    // captured transaction
    logic [KIND_W-1:0]   kind_reg;
    logic                cls_reg;
    logic [TAG_BITS-1:0] tag_reg;

    logic [PTR_W-1:0]    head_reg  [NUM_CLS];
    logic [PTR_W-1:0]    tail_reg  [NUM_CLS];
    logic [CNT_W-1:0]    count_reg [NUM_CLS];
    logic [STAMP_W-1:0]  arrival_reg;
    logic [ENT_W-1:0]    head_ent_reg [NUM_CLS];

    logic [STATUS_W-1:0] status_reg;
    logic                class_reg;
    logic [TAG_W-1:0]    otag_reg;

    logic                push_en [NUM_CLS];
    logic                pop_en  [NUM_CLS];
    logic                nonempty [NUM_CLS];
    logic                full     [NUM_CLS];
    logic [STAMP_W-1:0]  stamp_diff;
    logic                take;
    logic                take_cls;
    status_t             status_next;
    logic [TAG_BITS-1:0] take_tag;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            cls_reg  <= item_class;
            tag_reg  <= TAG_BITS'(item_tag);
        end
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CLS; c++)
        begin
            nonempty[c] = (count_reg[c] != '0);
            full[c]     = (count_reg[c] == CNT_W'(QUEUE_DEPTH));
        end
    end

    // wrap-aware age: first head older when the stamp difference is negative
    assign stamp_diff = head_ent_reg[0][STAMP_W-1:0] - head_ent_reg[1][STAMP_W-1:0];

    always_comb
    begin
        take        = 1'b0;
        take_cls    = 1'b0;
        status_next = ST_OK;
        for (int c = 0; c < NUM_CLS; c++)
        begin
            push_en[c] = 1'b0;
        end
        case (kind_reg)
            KIND_ENQ:
            begin
                if (full[cls_reg])
                    status_next = ST_FULL;
                else
                    push_en[cls_reg] = cmd.exec;
            end
            KIND_DEQ_ANY:
            begin
                if (nonempty[0] && nonempty[1])
                begin
                    take     = 1'b1;
                    take_cls = ~stamp_diff[STAMP_W-1];
                end
                else if (nonempty[0] || nonempty[1])
                begin
                    take     = 1'b1;
                    take_cls = nonempty[1];
                end
                else
                begin
                    status_next = ST_EMPTY;
                end
            end
            KIND_DEQ_CLASS:
            begin
                if (nonempty[cls_reg])
                begin
                    take     = 1'b1;
                    take_cls = cls_reg;
                end
                else
                begin
                    status_next = ST_EMPTY;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
        for (int c = 0; c < NUM_CLS; c++)
        begin
            pop_en[c] = cmd.exec && take && (take_cls == 1'(c));
        end
    end

    assign take_tag = head_ent_reg[take_cls][ENT_W-1:STAMP_W];

    for (genvar g = 0; g < NUM_CLS; g++)
    begin : g_queue
        logic [ENT_W-1:0] mem [QUEUE_DEPTH];

        always_ff @(posedge clk)
        begin
            if (push_en[g])
                mem[tail_reg[g]] <= {tag_reg, arrival_reg};
            head_ent_reg[g] <= mem[head_reg[g]];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                head_reg[g]  <= '0;
                tail_reg[g]  <= '0;
                count_reg[g] <= '0;
            end
            else
            begin
                if (push_en[g])
                begin
                    tail_reg[g]  <= next_slot(tail_reg[g]);
                    count_reg[g] <= count_reg[g] + CNT_W'(1);
                end
                else if (pop_en[g])
                begin
                    head_reg[g]  <= next_slot(head_reg[g]);
                    count_reg[g] <= count_reg[g] - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            arrival_reg <= '0;
        else if (push_en[0] || push_en[1])
            arrival_reg <= arrival_reg + STAMP_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg <= status_next;
            class_reg  <= take && take_cls;
            otag_reg   <= take ? TAG_W'(take_tag) : '0;
        end
    end

    assign status    = status_reg;
    assign out_class = class_reg;
    assign out_tag   = otag_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tcq_ctrl.sv =====
// sequencing state machine and response valid
`default_nettype none

module tcq_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output tcq_pkg::ctrl_cmd_t      cmd
);
    import tcq_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        rsp_valid_reg, rsp_valid_next;
    logic        go;

    // the result register is free, or empties in this cycle
    assign go = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (req_valid)
                    state_next = CS_LOOKUP;
            end
            CS_LOOKUP:
            begin
                state_next = CS_EXEC;
            end
            CS_EXEC:
            begin
                if (go)
                    state_next = CS_IDLE;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        cmd       = '0;
        case (state_reg)
            CS_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            CS_LOOKUP:
            begin
                req_ready = 1'b0;
            end
            CS_EXEC:
            begin
                cmd.exec = go;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.exec)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/two_class_oldest_first_queue_core.sv =====
// Two FIFOs, one per class, each entry holding a tag and an 8-bit arrival stamp from a
// shared counter that advances on every stored enqueue. A request enqueues into a class,
// dequeues the head of a class, or dequeues the older of the two heads (wrap-aware stamp
// compare, the second class wins a tie). Each request gives one response with status ok,
// empty or full; a full queue drops the enqueue. A request passes three steps: capture at
// acceptance, registered read of the two head entries from the queue memories, then
// execute, after which its response is presented. A new request is taken only after
// the previous one executes, so requests are never accepted back to back; an unread
// response holds the next request in its execute step.
`default_nettype none

module two_class_oldest_first_queue_core #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tcq_req_if.sink   req,
    tcq_rsp_if.source rsp
);
    import tcq_pkg::*;

    ctrl_cmd_t cmd;

    tcq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    tcq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .kind       (req.kind),
        .item_class (req.item_class),
        .item_tag   (req.item_tag),
        .status     (rsp.status),
        .out_class  (rsp.out_class),
        .out_tag    (rsp.out_tag)
    );

endmodule

`default_nettype wire

// ===== rtl/core/tcq_checker.sv =====
// port-level checks for the queue core and their bind
`default_nettype none

`include "assert_macros.svh"

module tcq_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          req_valid,
    input wire logic                          req_ready,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_ready,
    input wire logic [tcq_pkg::STATUS_W-1:0]  status,
    input wire logic                          out_class,
    input wire logic [tcq_pkg::TAG_W-1:0]     out_tag
);
    import tcq_pkg::*;

    logic req_hs;
    logic rsp_stall;

    assign req_hs    = req_valid && req_ready;
    assign rsp_stall = rsp_valid && !rsp_ready;

    `TCQ_ASSERT_NEXT(a_rsp_valid_holds, clk, rst_n, rsp_stall, rsp_valid, "response dropped while stalled")
    `TCQ_ASSERT_NEXT(a_rsp_payload_holds, clk, rst_n, rsp_stall, $stable(status) && $stable(out_class) && $stable(out_tag), "response payload changed while stalled")
    // one transaction in flight: no request taken on the cycle after another
    `TCQ_ASSERT_NEXT(a_req_spacing, clk, rst_n, req_hs, !req_hs, "requests accepted back to back")
    // a failed response (status not ok) carries no class and no tag
    `TCQ_ASSERT(a_no_deq_zero, clk, rst_n, !(rsp_valid && status != ST_OK) || (out_class == 1'b0 && out_tag == '0), "failed request carries tag or class")

endmodule

bind two_class_oldest_first_queue_core tcq_checker u_tcq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (rsp.status),
    .out_class (rsp.out_class),
    .out_tag   (rsp.out_tag)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// testbench for the two-class oldest-first queue core
module tb_top;
    import tcq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;
    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 900;
    localparam int QUIET_ITEMS = 100;
    localparam int FIRST_CHURN_ITEMS = 600;
    localparam int MAX_REPORTS = 40;

    localparam int MODE_MIXED = 0;
    localparam int MODE_FILL  = 1;
    localparam int MODE_DRAIN = 2;
    localparam int MODE_CHURN = 3;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } slot_t;

    typedef struct {
        status_t          status;
        logic             out_class;
        logic [TAG_W-1:0] out_tag;
    } outcome_t;

    class queue_scoreboard;
        slot_t              first_q[$];
        slot_t              second_q[$];
        logic [STAMP_W-1:0] arrival = '0;
        outcome_t           outcome_q[$];

        function int depth_of(logic cls);
            return cls ? second_q.size() : first_q.size();
        endfunction

        function bit heads_tied();
            return first_q.size() > 0 && second_q.size() > 0
                && first_q[0].stamp == second_q[0].stamp;
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction

        function void note_request(logic [KIND_W-1:0] kind, logic cls, logic [TAG_W-1:0] tag);
            outcome_t           o;
            slot_t              s;
            logic [STAMP_W-1:0] diff;
            int                 take;
            o.status    = ST_OK;
            o.out_class = 1'b0;
            o.out_tag   = '0;
            take        = -1;
            case (kind)
                KIND_ENQ:
                begin
                    if (depth_of(cls) >= QUEUE_DEPTH)
                        o.status = ST_FULL;
                    else
                    begin
                        s = '{tag, arrival};
                        if (cls)
                            second_q = {second_q, s};
                        else
                            first_q = {first_q, s};
                        arrival = arrival + 1'b1;
                    end
                end
                KIND_DEQ_ANY:
                begin
                    if (first_q.size() > 0 && second_q.size() > 0)
                    begin
                        // wrap-aware age: first head is older when the difference is negative
                        diff = first_q[0].stamp - second_q[0].stamp;
                        take = diff[STAMP_W-1] ? 0 : 1;
                    end
                    else if (first_q.size() > 0)
                        take = 0;
                    else if (second_q.size() > 0)
                        take = 1;
                    else
                        o.status = ST_EMPTY;
                end
                KIND_DEQ_CLASS:
                begin
                    if (depth_of(cls) > 0)
                        take = cls ? 1 : 0;
                    else
                        o.status = ST_EMPTY;
                end
                default: ;
            endcase
            if (take == 0)
            begin
                s = first_q[0];
                first_q.delete(0);
                o.out_tag = s.tag;
            end
            else if (take == 1)
            begin
                s = second_q[0];
                second_q.delete(0);
                o.out_tag   = s.tag;
                o.out_class = 1'b1;
            end
            outcome_q = {outcome_q, o};
        endfunction

        function string check_response(logic [STATUS_W-1:0] status, logic out_class,
                                       logic [TAG_W-1:0] out_tag);
            outcome_t o;
            string    msg;
            if (outcome_q.size() == 0)
                return $sformatf("response with nothing outstanding: status %0d class %0d tag %h",
                                 status, out_class, out_tag);
            o = outcome_q[0];
            outcome_q.delete(0);
            msg = "";
            if (status !== o.status)
                msg = {msg, $sformatf(" status %0d exp %0d", status, o.status)};
            if (out_class !== o.out_class)
                msg = {msg, $sformatf(" class %0d exp %0d", out_class, o.out_class)};
            if (out_tag !== o.out_tag)
                msg = {msg, $sformatf(" tag %h exp %h", out_tag, o.out_tag)};
            if (msg == "")
                return "";
            return {"response mismatch:", msg};
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   gaps_on;
    int   error_count;
    int   idle_cycles;
    int   stall_left;

    queue_scoreboard sb;

    tcq_req_if req_if();
    tcq_rsp_if rsp_if();

    two_class_oldest_first_queue_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_W)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always #6 clk = ~clk;

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR at %0t:%s", $time, msg);
    endtask

    // request side: optional idle burst, then hold the transaction until taken
    task automatic issue_request(logic [KIND_W-1:0] kind, logic cls, logic [TAG_W-1:0] tag);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.kind       <= kind;
        req_if.item_class <= cls;
        req_if.item_tag   <= tag;
        do
            @(posedge clk);
        while (!req_if.ready);
        sb.note_request(kind, cls, tag);
    endtask

    // response side: check every transaction, stall in random bursts
    always @(posedge clk)
    begin : rsp_side
        string msg;
        if (rsp_if.valid && rsp_if.ready)
        begin
            msg = sb.check_response(rsp_if.status, rsp_if.out_class, rsp_if.out_tag);
            if (msg != "")
                report_mismatch(msg);
        end
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_if.ready <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 10) - 1;
            rsp_if.ready <= 1'b0;
        end
        else
            rsp_if.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL two_class_oldest_first_queue_core");
            $finish;
        end
    end

    task automatic run_directed();
        issue_request(KIND_DEQ_ANY, 1'b0, 16'h1234);
        issue_request(KIND_DEQ_CLASS, 1'b0, 16'h0000);
        issue_request(KIND_DEQ_CLASS, 1'b1, 16'hffff);
        issue_request(KIND_NOP, 1'b1, 16'hffff);
        issue_request(KIND_ENQ, 1'b0, 16'h0000);
        issue_request(KIND_ENQ, 1'b1, 16'hffff);
        issue_request(KIND_DEQ_ANY, 1'b1, 16'h0000);
        issue_request(KIND_DEQ_ANY, 1'b0, 16'hffff);
        issue_request(KIND_ENQ, 1'b1, 16'ha5a5);
        issue_request(KIND_ENQ, 1'b0, 16'h5a5a);
        // second class is older here, so it goes first
        issue_request(KIND_DEQ_ANY, 1'b0, 16'h0000);
        // fill the first class and push one more to see it dropped
        for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            issue_request(KIND_ENQ, 1'b0, TAG_W'(16'h8000 + i));
        issue_request(KIND_ENQ, 1'b0, 16'hdead);
        issue_request(KIND_DEQ_CLASS, 1'b1, 16'h0000);
        issue_request(KIND_DEQ_CLASS, 1'b0, 16'h0000);
    endtask

    task automatic run_random();
        int                sent;
        int                mode;
        int                span;
        int                r;
        bit                first;
        logic              held;
        logic [KIND_W-1:0] kind;
        logic              cls;
        sent  = 0;
        first = 1'b1;
        held  = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            mode = first ? MODE_CHURN : $urandom_range(MODE_MIXED, MODE_CHURN);
            if (mode == MODE_CHURN)
                span = first ? FIRST_CHURN_ITEMS : $urandom_range(150, 300);
            else
                span = $urandom_range(20, 120);
            first = 1'b0;
            if (mode == MODE_CHURN)
            begin
                // park a few items in one class while the other one cycles past the stamp wrap
                held = 1'($urandom_range(0, 1));
                repeat (4)
                begin
                    issue_request(KIND_ENQ, held, TAG_W'($urandom_range(0, 65535)));
                    sent++;
                end
            end
            for (int i = 0; i < span && sent < RANDOM_ITEMS; i++)
            begin
                if (sent >= RANDOM_ITEMS - QUIET_ITEMS)
                    gaps_on = 1'b0;
                r   = $urandom_range(0, 99);
                cls = 1'($urandom_range(0, 1));
                case (mode)
                    MODE_FILL:
                        kind = r < 75 ? KIND_ENQ : r < 85 ? KIND_DEQ_ANY :
                               r < 95 ? KIND_DEQ_CLASS : KIND_NOP;
                    MODE_DRAIN:
                        kind = r < 20 ? KIND_ENQ : r < 60 ? KIND_DEQ_ANY :
                               r < 95 ? KIND_DEQ_CLASS : KIND_NOP;
                    MODE_CHURN:
                    begin
                        if (sb.heads_tied())
                            kind = KIND_DEQ_ANY;
                        else if (r < 48)
                        begin
                            kind = KIND_ENQ;
                            cls  = ~held;
                        end
                        else if (r < 96)
                        begin
                            kind = KIND_DEQ_CLASS;
                            cls  = ~held;
                        end
                        else if (r < 98)
                            kind = KIND_DEQ_ANY;
                        else
                            kind = KIND_W'($urandom_range(0, 3));
                    end
                    default:
                        kind = r < 40 ? KIND_ENQ : r < 65 ? KIND_DEQ_ANY :
                               r < 90 ? KIND_DEQ_CLASS : KIND_NOP;
                endcase
                issue_request(kind, cls, TAG_W'($urandom_range(0, 65535)));
                sent++;
            end
        end
    endtask

    initial
    begin
        clk               = 1'b0;
        sb                = new;
        error_count       = 0;
        idle_cycles       = 0;
        stall_left        = 0;
        gaps_on           = 1'b1;
        rst_n             = 1'b0;
        req_if.valid      = 1'b0;
        req_if.kind       = '0;
        req_if.item_class = 1'b0;
        req_if.item_tag   = '0;
        rsp_if.ready      = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        run_random();
        req_if.valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (error_count == 0)
            $display("PASS two_class_oldest_first_queue_core");
        else
            $display("FAIL two_class_oldest_first_queue_core");
        $finish;
    end

endmodule
